// ----- hw/rtl/dq_pkg.sv -----
// Shared types and codes for the double-ended queue with search.
`timescale 1ns / 1ps
`default_nettype none
package dq_pkg;
    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int POS_W = 5;

    typedef logic [CMD_W-1:0]        t_cmd;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [ST_W-1:0]         t_status;
    typedef logic [POS_W-1:0]        t_pos;

    localparam t_cmd CMD_INS_FRONT = 3'd0;
    localparam t_cmd CMD_INS_BACK  = 3'd1;
    localparam t_cmd CMD_DEL_FRONT = 3'd2;
    localparam t_cmd CMD_DEL_BACK  = 3'd3;
    localparam t_cmd CMD_SEARCH    = 3'd4;
    localparam t_cmd CMD_TRAVERSE  = 3'd5;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;
endpackage
`default_nettype wire

// ----- hw/rtl/dq_if.sv -----
// Valid/ready channel interfaces for command items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface dq_in_if;
    import dq_pkg::*;
    logic valid;
    logic ready;
    t_cmd cmd;
    t_val value_in;
    modport source (output valid, output cmd, output value_in, input ready);
    modport sink (input valid, input cmd, input value_in, output ready);
endinterface

interface dq_out_if;
    import dq_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    t_val    value_out;
    t_pos    position;
    logic    last;
    modport source (output valid, output status, output value_out, output position,
                    output last, input ready);
    modport sink (input valid, input status, input value_out, input position,
                  input last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dq_mem.sv -----
// Ring store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dq_mem #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire dq_pkg::t_val  i_wdata,
    input  wire logic          i_re,
    input  wire logic [IW-1:0] i_raddr,
    output dq_pkg::t_val       o_rdata
);
    import dq_pkg::*;

    t_val r_mem [DEPTH];
    t_val r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- hw/rtl/deque_with_search_top.sv -----
// Top level: command sequencer, ring pointers and result register of the deque.
// Insert and delete: accept the item, then load the result register in S_EMIT once the output is free.
// Search and traverse: each visited entry passes S_RADDR (issue the read), then S_RDATA (compare or emit),
// where the entry's data arrives from the store's registered read port.
// A new item is taken while the previous result waits in the output register.
// Synchronous active-low reset empties the store (head 0, count 0); data is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module deque_with_search_top #(
    parameter int DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dq_in_if.sink     i_in,
    dq_out_if.source  o_out
);
    import dq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EMIT  = 2'd1;
    localparam logic [1:0] S_RADDR = 2'd2;
    localparam logic [1:0] S_RDATA = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    t_cmd          r_cmd, n_cmd;
    t_val          r_key, n_key;
    t_status       r_pst, n_pst;

    logic    r_ov;
    t_status r_status;
    t_val    r_value;
    t_pos    r_pos;
    logic    r_last;

    logic    res_load;
    t_status res_status;
    t_val    res_value;
    t_pos    res_pos;
    logic    res_last;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    t_val          mem_rdata;

    logic          out_free;
    logic          acc;
    logic          full;
    logic          empty;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;
    logic [CW:0]   back_sum;
    logic [IW-1:0] back_slot;
    logic [CW:0]   walk_sum;
    logic [CW:0]   idx_p1;
    logic          is_last;

    assign out_free   = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign acc        = i_in.valid && i_in.ready;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign head_dec   = (r_head == '0) ? IW'(DEPTH - 1) : r_head - IW'(1);
    assign head_inc   = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + IW'(1);
    assign back_sum   = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign back_slot  = (back_sum >= (CW+1)'(DEPTH)) ? IW'(back_sum - (CW+1)'(DEPTH))
                                                     : IW'(back_sum);
    assign walk_sum   = (CW+1)'(r_head) + (CW+1)'(r_idx);
    assign mem_raddr  = (walk_sum >= (CW+1)'(DEPTH)) ? IW'(walk_sum - (CW+1)'(DEPTH))
                                                     : IW'(walk_sum);
    assign idx_p1     = (CW+1)'(r_idx) + (CW+1)'(1);
    assign is_last    = (idx_p1 == (CW+1)'(r_count));

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_pst      = r_pst;
        mem_we     = 1'b0;
        mem_waddr  = back_slot;
        mem_re     = 1'b0;
        res_load   = 1'b0;
        res_status = ST_OK;
        res_value  = '0;
        res_pos    = '0;
        res_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_cmd = i_in.cmd;
                    n_key = i_in.value_in;
                    n_idx = '0;
                    unique case (i_in.cmd)
                        CMD_INS_FRONT, CMD_INS_BACK: begin
                            n_state = S_EMIT;
                            if (full) begin
                                n_pst = ST_FULL;
                            end else begin
                                n_pst   = ST_OK;
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_in.cmd == CMD_INS_FRONT) begin
                                    mem_waddr = head_dec;
                                    n_head    = head_dec;
                                end
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK: begin
                            n_state = S_EMIT;
                            if (empty) begin
                                n_pst = ST_EMPTY;
                            end else begin
                                n_pst   = ST_OK;
                                n_count = r_count - CW'(1);
                                if (i_in.cmd == CMD_DEL_FRONT) begin
                                    n_head = head_inc;
                                end
                            end
                        end
                        CMD_SEARCH, CMD_TRAVERSE: begin
                            if (empty) begin
                                n_pst   = ST_EMPTY;
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_RADDR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    res_status = r_pst;
                    n_state    = S_IDLE;
                end
            end
            S_RADDR: begin
                mem_re  = 1'b1;
                n_state = S_RDATA;
            end
            S_RDATA: begin
                if (out_free) begin
                    if (r_cmd == CMD_TRAVERSE) begin
                        res_load  = 1'b1;
                        res_value = mem_rdata;
                        res_pos   = POS_W'(idx_p1);
                        res_last  = is_last;
                        n_idx     = CW'(idx_p1);
                        n_state   = is_last ? S_IDLE : S_RADDR;
                    end else if (mem_rdata == r_key) begin
                        res_load  = 1'b1;
                        res_value = r_key;
                        res_pos   = POS_W'(idx_p1);
                        n_state   = S_IDLE;
                    end else if (is_last) begin
                        res_load   = 1'b1;
                        res_status = ST_NOTFOUND;
                        n_state    = S_IDLE;
                    end else begin
                        n_idx   = CW'(idx_p1);
                        n_state = S_RADDR;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (res_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cmd <= n_cmd;
        r_key <= n_key;
        r_pst <= n_pst;
        if (res_load) begin
            r_status <= res_status;
            r_value  <= res_value;
            r_pos    <= res_pos;
            r_last   <= res_last;
        end
    end

    dq_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (n_key),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out.valid     = r_ov;
    assign o_out.status    = r_status;
    assign o_out.value_out = r_value;
    assign o_out.position  = r_pos;
    assign o_out.last      = r_last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= IW'(DEPTH - 1))
        else $error("head index out of range");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RADDR || r_state == S_RDATA) |-> (r_idx < r_count))
        else $error("walk index past tail");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_in.cmd == CMD_INS_FRONT || i_in.cmd == CMD_INS_BACK) && !full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the store");

    a_no_load_on_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |-> !res_load)
        else $error("result overwritten while held");
`endif
endmodule
`default_nettype wire
